// ===== hdl/htc_pkg.sv =====
`default_nettype none

package htc_pkg;

    localparam int STAGES = 6;
    localparam int SUM_W = 48;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LOW = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_HIGH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HUM_LOW = 8'd3;

    localparam logic [7:0] TEMP_HIGH_RESET = 8'd0;
    localparam logic [7:0] TEMP_LOW_RESET = 8'd1;
    localparam logic [7:0] HUM_HIGH_RESET = 8'd2;
    localparam logic [7:0] HUM_LOW_RESET = 8'd3;

    // Humidity coefficients, scaled by 2^24.
    localparam logic signed [SUM_W-1:0] K1 = -48'sd3433960571;
    localparam logic [41:0] K2 = 42'd61572383;
    localparam logic [43:0] K3 = 44'd2677;
    localparam logic [27:0] D1 = 28'd167772;
    localparam logic [27:0] D2 = 28'd1342;

    localparam logic signed [16:0] TEMP_BIAS = 17'sd3970;
    localparam logic signed [17:0] TEMP_BIAS_REF = 18'sd6470;
    localparam logic signed [SUM_W-1:0] HIGH_LIMIT = 48'sd166094438400;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = 48'sd8388608;
    localparam logic [13:0] HUM_SATURATED = 14'd10000;

    typedef struct packed {
        logic [7:0] temp_high_offset;
        logic [7:0] temp_low_offset;
        logic [7:0] hum_high_offset;
        logic [7:0] hum_low_offset;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/humidity_temperature_convert_unit.sv =====
// Converts raw temperature and humidity sensor readings to hundredths of a
// degree Celsius and hundredths of percent relative humidity.
// Input words arrive on the s_ stream channel and results leave on the m_
// channel; a word moves when tvalid and tready are both high.
// The four byte offset registers are written through the cfg_ channel,
// which is always ready; write them only while no word is in flight.
// Every input word gives exactly one result word. The result passes
// through a six-stage pipeline whose stages hold the multipliers and wide
// adders, and the last stage is the output register.
// One word can be accepted every cycle while s_tready is high.
// When the receiver stalls, words collect in empty stages behind the output
// register, and s_tready falls only once all six stages are full.
// Nothing is lost or repeated across a stall.
// Reset empties the pipeline and loads the offsets 0, 1, 2 and 3.
`default_nettype none

module humidity_temperature_convert_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // data_length, temp_raw, hum_raw
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // temp_centi, hum_centi, then zero fill
    output logic [31:0]      m_tdata,
    // temp_ok, hum_ok
    output logic [1:0]       m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [htc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]  cfg_data
);

    htc_pkg::cfg_t      cfg_reg;
    logic               temp_ok;
    logic               hum_ok;
    logic signed [16:0] temp_centi;
    logic [13:0]        hum_centi;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.temp_high_offset <= htc_pkg::TEMP_HIGH_RESET;
            cfg_reg.temp_low_offset  <= htc_pkg::TEMP_LOW_RESET;
            cfg_reg.hum_high_offset  <= htc_pkg::HUM_HIGH_RESET;
            cfg_reg.hum_low_offset   <= htc_pkg::HUM_LOW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                htc_pkg::REG_TEMP_HIGH: begin
                    cfg_reg.temp_high_offset <= cfg_data;
                end
                htc_pkg::REG_TEMP_LOW: begin
                    cfg_reg.temp_low_offset <= cfg_data;
                end
                htc_pkg::REG_HUM_HIGH: begin
                    cfg_reg.hum_high_offset <= cfg_data;
                end
                htc_pkg::REG_HUM_LOW: begin
                    cfg_reg.hum_low_offset <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    htc_pipe u_pipe (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_length (s_tdata[7:0]),
        .temp_raw    ($signed(s_tdata[23:8])),
        .hum_raw     (s_tdata[39:24]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .temp_ok     (temp_ok),
        .temp_centi  (temp_centi),
        .hum_ok      (hum_ok),
        .hum_centi   (hum_centi)
    );

    assign m_tdata = {1'b0, hum_centi, temp_centi};
    assign m_tuser = {hum_ok, temp_ok};

endmodule

`default_nettype wire

// ===== hdl/htc_pipe.sv =====
`default_nettype none

module htc_pipe (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire htc_pkg::cfg_t       cfg,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [7:0]          data_length,
    input  wire logic signed [15:0]  temp_raw,
    input  wire logic [15:0]         hum_raw,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     temp_ok,
    output logic signed [16:0]       temp_centi,
    output logic                     hum_ok,
    output logic [13:0]              hum_centi
);

    logic [htc_pkg::STAGES-1:0] valid_reg;
    logic [htc_pkg::STAGES-1:0] valid_next;
    logic [htc_pkg::STAGES-1:0] en;
    logic [htc_pkg::STAGES-1:0] tok_reg;
    logic [htc_pkg::STAGES-1:0] hok_reg;
    logic tok_next;
    logic hok_next;

    logic signed [15:0] traw1_reg;
    logic [15:0]        rh1_reg;

    logic signed [16:0] tc2_reg, tc2_next;
    logic signed [17:0] tdiff2_reg, tdiff2_next;
    logic [31:0]        rhsq2_reg, rhsq2_next;
    logic [27:0]        dsum2_reg, dsum2_next;
    logic [41:0]        k2rh2_reg, k2rh2_next;

    logic signed [16:0]         tc3_reg;
    logic [43:0]                k3term3_reg, k3term3_next;
    logic signed [46:0]         tprod3_reg, tprod3_next;
    logic signed [htc_pkg::SUM_W-1:0] lin3_reg, lin3_next;

    logic signed [16:0]         tc4_reg;
    logic signed [46:0]         tprod4_reg;
    logic signed [htc_pkg::SUM_W-1:0] part4_reg, part4_next;

    logic signed [16:0]         tc5_reg;
    logic signed [htc_pkg::SUM_W-1:0] sum5_reg, sum5_next;
    logic signed [htc_pkg::SUM_W-1:0] rnd5;

    logic signed [16:0] temp_centi_reg, temp_centi_next;
    logic [13:0]        hum_centi_reg, hum_centi_next;

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        en[htc_pkg::STAGES-1] = !valid_reg[htc_pkg::STAGES-1] || out_ready;
        for (int k = htc_pkg::STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < htc_pkg::STAGES; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_comb begin
        tok_next = (data_length > cfg.temp_high_offset) && (data_length > cfg.temp_low_offset);
        hok_next = tok_next && (data_length > cfg.hum_high_offset)
                   && (data_length > cfg.hum_low_offset);

        tc2_next    = {traw1_reg[15], traw1_reg} - htc_pkg::TEMP_BIAS;
        tdiff2_next = {{2{traw1_reg[15]}}, traw1_reg} - htc_pkg::TEMP_BIAS_REF;
        rhsq2_next  = {16'b0, rh1_reg} * {16'b0, rh1_reg};
        dsum2_next  = htc_pkg::D2 * {12'b0, rh1_reg} + htc_pkg::D1;
        k2rh2_next  = htc_pkg::K2 * {26'b0, rh1_reg};

        k3term3_next = htc_pkg::K3 * {12'b0, rhsq2_reg};
        tprod3_next  = {{29{tdiff2_reg[17]}}, tdiff2_reg} * $signed({19'b0, dsum2_reg});
        lin3_next    = htc_pkg::K1 + $signed({6'b0, k2rh2_reg});

        part4_next = lin3_reg - $signed({4'b0, k3term3_reg});

        sum5_next = part4_reg + {tprod4_reg[46], tprod4_reg};

        rnd5 = sum5_reg + htc_pkg::ROUND_HALF;
        temp_centi_next = tok_reg[4] ? tc5_reg : '0;
        if (!hok_reg[4] || sum5_reg <= 0) begin
            hum_centi_next = '0;
        end else if (sum5_reg > htc_pkg::HIGH_LIMIT) begin
            hum_centi_next = htc_pkg::HUM_SATURATED;
        end else begin
            hum_centi_next = rnd5[37:24];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tok_reg[0] <= tok_next;
            hok_reg[0] <= hok_next;
            traw1_reg  <= temp_raw;
            rh1_reg    <= hum_raw;
        end
        if (en[1]) begin
            tok_reg[1] <= tok_reg[0];
            hok_reg[1] <= hok_reg[0];
            tc2_reg    <= tc2_next;
            tdiff2_reg <= tdiff2_next;
            rhsq2_reg  <= rhsq2_next;
            dsum2_reg  <= dsum2_next;
            k2rh2_reg  <= k2rh2_next;
        end
        if (en[2]) begin
            tok_reg[2]  <= tok_reg[1];
            hok_reg[2]  <= hok_reg[1];
            tc3_reg     <= tc2_reg;
            k3term3_reg <= k3term3_next;
            tprod3_reg  <= tprod3_next;
            lin3_reg    <= lin3_next;
        end
        if (en[3]) begin
            tok_reg[3] <= tok_reg[2];
            hok_reg[3] <= hok_reg[2];
            tc4_reg    <= tc3_reg;
            tprod4_reg <= tprod3_reg;
            part4_reg  <= part4_next;
        end
        if (en[4]) begin
            tok_reg[4] <= tok_reg[3];
            hok_reg[4] <= hok_reg[3];
            tc5_reg    <= tc4_reg;
            sum5_reg   <= sum5_next;
        end
        if (en[5]) begin
            tok_reg[5]     <= tok_reg[4];
            hok_reg[5]     <= hok_reg[4];
            temp_centi_reg <= temp_centi_next;
            hum_centi_reg  <= hum_centi_next;
        end
    end

    assign out_valid  = valid_reg[htc_pkg::STAGES-1];
    assign temp_ok    = tok_reg[htc_pkg::STAGES-1];
    assign hum_ok     = hok_reg[htc_pkg::STAGES-1];
    assign temp_centi = temp_centi_reg;
    assign hum_centi  = hum_centi_reg;

    a_hum_needs_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (temp_ok || !hum_ok))
        else $error("humidity flagged valid without temperature");

    a_hum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (hum_centi <= htc_pkg::HUM_SATURATED))
        else $error("humidity above saturation value");

    a_temp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !temp_ok) |-> (temp_centi == '0 && hum_centi == '0))
        else $error("invalid reading carries nonzero fields");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> (&valid_reg))
        else $error("input stalled while the pipeline has a free stage");

endmodule

`default_nettype wire
